/* hw/rtl/range_line_fit_median_top_assert.svh */
// Assertion macros used by the top-level RTL file to check its own behavior.
// Every macro samples on the rising edge of clk and is disabled during reset.
`ifndef RANGE_LINE_FIT_MEDIAN_TOP_ASSERT_SVH
`define RANGE_LINE_FIT_MEDIAN_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RLFM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RLFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RLFM_ASSERT_NOW(label, ante, cons)
`define RLFM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/rlfm_pkg.sv */
`default_nettype none
package rlfm_pkg;

    localparam int AVERAGE_DEPTH = 9;
    localparam int MEDIAN_DEPTH  = 5;
    localparam int RANGE_BITS    = 16;
    localparam int BEAMS         = 5;

    localparam int RANGE_IN_W  = 16;
    localparam int RANGE_EXT_W = 24;
    localparam int FRAC        = 28 - RANGE_BITS;
    localparam int BFRAC       = 16 - FRAC;
    localparam int AVG_W       = RANGE_BITS + FRAC;
    localparam int SUM_W       = RANGE_BITS + $clog2(AVERAGE_DEPTH);
    localparam int NUM_W       = SUM_W + FRAC;
    localparam int FILL_W      = $clog2(AVERAGE_DEPTH + 1);
    localparam int MFILL_W     = $clog2(MEDIAN_DEPTH + 1);
    localparam int MIDX_W      = $clog2(MEDIAN_DEPTH);
    localparam int COEF_W      = 16;
    localparam int CRD_W       = 32;
    localparam int ACC_W       = 64;

    // Slope divider: 80-bit dividend, 64-bit divisor, 34-bit quotient.
    localparam int DVD_W  = 80;
    localparam int DVS_W  = 64;
    localparam int QUO_W  = 34;
    localparam int DCNT_W = $clog2(DVD_W);

    // Division by five as a multiply by ceil(2^21 / 5) and a shift; exact below 2^21 / 3.
    localparam logic [18:0] RECIP_FIVE       = 19'd419431;
    localparam int          RECIP_FIVE_SHIFT = 21;

    localparam logic [COEF_W-1:0] COS_MAG [BEAMS] =
        '{16'd32746, 16'd32762, 16'd32768, 16'd32762, 16'd32746};
    localparam logic [COEF_W-1:0] SIN_MAG [BEAMS] =
        '{16'd1206, 16'd603, 16'd0, 16'd603, 16'd1206};
    // Beams left of center have a negative sine.
    localparam logic [BEAMS-1:0] SIN_NEG = 5'b00011;

    typedef struct packed {
        logic signed [CRD_W-1:0] slope;
        logic signed [CRD_W-1:0] intercept;
        logic                    degenerate;
    } rlfm_fit_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] slope;
        logic signed [CRD_W-1:0] intercept;
        logic                    flip;
        logic                    degenerate;
    } rlfm_result_t;

endpackage
`default_nettype wire

/* hw/rtl/rlfm_scan_if.sv */
`default_nettype none
interface rlfm_scan_if;
    logic                             valid;
    logic                             ready;
    logic [rlfm_pkg::RANGE_IN_W-1:0] range_beam0;
    logic [rlfm_pkg::RANGE_IN_W-1:0] range_beam1;
    logic [rlfm_pkg::RANGE_IN_W-1:0] range_beam2;
    logic [rlfm_pkg::RANGE_IN_W-1:0] range_beam3;
    logic [rlfm_pkg::RANGE_IN_W-1:0] range_beam4;

    modport source (output valid, range_beam0, range_beam1, range_beam2, range_beam3,
                    range_beam4, input ready);
    modport sink (input valid, range_beam0, range_beam1, range_beam2, range_beam3,
                  range_beam4, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rlfm_result_if.sv */
`default_nettype none
interface rlfm_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [rlfm_pkg::CRD_W-1:0] median_slope;
    logic signed [rlfm_pkg::CRD_W-1:0] median_intercept;
    logic                               slope_sign_flip;
    logic                               degenerate_fit;

    modport source (output valid, median_slope, median_intercept, slope_sign_flip,
                    degenerate_fit, input ready);
    modport sink (input valid, median_slope, median_intercept, slope_sign_flip,
                  degenerate_fit, output ready);
endinterface
`default_nettype wire

/* hw/rtl/range_line_fit_median_top.sv */
// Straight-line fit over five laser beams with a median filter on the slope.
// Input channel scan: one transfer carries the five ranges of one scan.
// Output channel result: one transfer per scan with the median slope (Q16.16),
// the intercept of the same fit in millimeters, a sign-flip flag and a
// degenerate-fit flag.
// The block works on one scan at a time; scan.ready rises as the result is loaded,
// so no new scan is taken before the last one is through. The processing runs the
// 32-step average division in the beam lanes, the 80-step slope divider and a
// three-step division by five for the intercept; a degenerate fit skips the last two.
// A finished result waits in the output register; scan.ready is high meanwhile,
// and if the next result is ready before the receiver takes the old one the
// block holds it and keeps scan.ready low until the transfer.
// Reset clears the range history, the fit window, the fill counts and the
// previous median; no clearing pass is needed.
`default_nettype none
module range_line_fit_median_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rlfm_scan_if.sink        scan,
    rlfm_result_if.source    result
);
    localparam int BEAMS  = rlfm_pkg::BEAMS;
    localparam int FILL_W = rlfm_pkg::FILL_W;
    localparam int CRD_W  = rlfm_pkg::CRD_W;

    typedef enum logic [2:0] {T_IDLE, T_LANE, T_FIT, T_MED, T_HOLD} top_state_t;

    top_state_t              state_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic                    fit_start_reg;
    logic                    med_start_reg;
    logic                    out_valid_reg;
    rlfm_pkg::rlfm_result_t  out_reg;

    logic                    accept;
    logic [FILL_W-1:0]       fill_next;
    logic [rlfm_pkg::RANGE_IN_W-1:0] ranges [BEAMS];
    logic [BEAMS-1:0]        lane_done;
    logic signed [CRD_W-1:0] lane_x [BEAMS];
    logic signed [CRD_W-1:0] lane_y [BEAMS];
    logic                    fit_done;
    rlfm_pkg::rlfm_fit_t     fit_val;
    logic                    med_done;
    rlfm_pkg::rlfm_result_t  med_val;

    assign scan.ready = (state_reg == T_IDLE);
    assign accept     = scan.valid && scan.ready;
    assign fill_next  = (fill_reg < FILL_W'(rlfm_pkg::AVERAGE_DEPTH)) ? fill_reg + 1'b1
                                                                      : fill_reg;
    assign ranges[0]  = scan.range_beam0;
    assign ranges[1]  = scan.range_beam1;
    assign ranges[2]  = scan.range_beam2;
    assign ranges[3]  = scan.range_beam3;
    assign ranges[4]  = scan.range_beam4;

    for (genvar g = 0; g < BEAMS; g++)
    begin : g_lane
        rlfm_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (accept),
            .range_in (ranges[g]),
            .fill     (fill_next),
            .cos_mag  (rlfm_pkg::COS_MAG[g]),
            .sin_mag  (rlfm_pkg::SIN_MAG[g]),
            .sin_neg  (rlfm_pkg::SIN_NEG[g]),
            .done     (lane_done[g]),
            .x        (lane_x[g]),
            .y        (lane_y[g])
        );
    end

    rlfm_fit u_fit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fit_start_reg),
        .x     (lane_x),
        .y     (lane_y),
        .done  (fit_done),
        .fit   (fit_val)
    );

    rlfm_median u_median (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (med_start_reg),
        .fit    (fit_val),
        .done   (med_done),
        .result (med_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            fill_reg      <= '0;
            fit_start_reg <= 1'b0;
            med_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fit_start_reg <= 1'b0;
            med_start_reg <= 1'b0;
            // In T_HOLD a transfer is followed by the next result in the same cycle.
            if (result.valid && result.ready && state_reg != T_HOLD)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        fill_reg  <= fill_next;
                        state_reg <= T_LANE;
                    end
                end
                T_LANE:
                begin
                    if (&lane_done)
                    begin
                        fit_start_reg <= 1'b1;
                        state_reg     <= T_FIT;
                    end
                end
                T_FIT:
                begin
                    if (fit_done)
                    begin
                        med_start_reg <= 1'b1;
                        state_reg     <= T_MED;
                    end
                end
                T_MED:
                begin
                    if (med_done)
                    begin
                        state_reg <= T_HOLD;
                    end
                end
                T_HOLD:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_reg       <= med_val;
                        out_valid_reg <= 1'b1;
                        state_reg     <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.median_slope     = out_reg.slope;
    assign result.median_intercept = out_reg.intercept;
    assign result.slope_sign_flip  = out_reg.flip;
    assign result.degenerate_fit   = out_reg.degenerate;

`include "range_line_fit_median_top_assert.svh"

    `RLFM_ASSERT_NEXT(a_accept_then_busy, accept, !scan.ready)
    `RLFM_ASSERT_NOW(a_degenerate_no_flip, result.valid && result.degenerate_fit,
                     !result.slope_sign_flip)
    `RLFM_ASSERT_NOW(a_fit_done_in_fit, fit_done, state_reg == T_FIT)
    `RLFM_ASSERT_NOW(a_lanes_done_together, |lane_done, &lane_done)
endmodule
`default_nettype wire

/* hw/rtl/rlfm_lane.sv */
`default_nettype none
module rlfm_lane (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [rlfm_pkg::RANGE_IN_W-1:0]     range_in,
    input  wire logic [rlfm_pkg::FILL_W-1:0]         fill,
    input  wire logic [rlfm_pkg::COEF_W-1:0]         cos_mag,
    input  wire logic [rlfm_pkg::COEF_W-1:0]         sin_mag,
    input  wire logic                                sin_neg,
    output logic                                     done,
    output logic signed [rlfm_pkg::CRD_W-1:0]        x,
    output logic signed [rlfm_pkg::CRD_W-1:0]        y
);
    localparam int D      = rlfm_pkg::AVERAGE_DEPTH;
    localparam int SUM_W  = rlfm_pkg::SUM_W;
    localparam int NUM_W  = rlfm_pkg::NUM_W;
    localparam int FILL_W = rlfm_pkg::FILL_W;
    localparam int AVG_W  = rlfm_pkg::AVG_W;
    localparam int CRD_W  = rlfm_pkg::CRD_W;
    localparam int PW     = AVG_W + rlfm_pkg::COEF_W;
    localparam int CNT_W  = $clog2(NUM_W);

    typedef enum logic [1:0] {L_IDLE, L_DIV, L_MUL, L_RND} lane_state_t;

    lane_state_t              state_reg;
    logic [rlfm_pkg::RANGE_BITS-1:0] hist_reg [D];
    logic [SUM_W-1:0]         sum_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [NUM_W-1:0]         quo_reg;
    logic [FILL_W-1:0]        rem_reg;
    logic [FILL_W-1:0]        div_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [PW-1:0]            px_reg;
    logic [PW-1:0]            py_reg;
    logic signed [CRD_W-1:0]  x_reg;
    logic signed [CRD_W-1:0]  y_reg;
    logic                     done_reg;

    logic [rlfm_pkg::RANGE_EXT_W-1:0] range_ext;
    logic [rlfm_pkg::RANGE_BITS-1:0]  range_cut;
    logic [SUM_W-1:0]         sum_next;
    logic [FILL_W:0]          rem_shift;
    logic                     qbit;
    logic [PW:0]              x_round;
    logic [PW:0]              y_round;
    logic signed [CRD_W-1:0]  y_mag;

    always_comb
    begin
        range_ext = {{(rlfm_pkg::RANGE_EXT_W - rlfm_pkg::RANGE_IN_W){1'b0}}, range_in};
        range_cut = range_ext[rlfm_pkg::RANGE_BITS-1:0];
        // Running sum: the oldest entry is still zero until the history is full.
        sum_next  = sum_reg + SUM_W'(range_cut) - SUM_W'(hist_reg[D-1]);
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        qbit      = (rem_shift >= {1'b0, div_reg});
        x_round   = {1'b0, px_reg} + (PW+1)'(16384);
        y_round   = {1'b0, py_reg} + (PW+1)'(16384);
        y_mag     = CRD_W'(y_round >> 15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            for (int k = 0; k < D; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        for (int k = D - 1; k > 0; k--)
                        begin
                            hist_reg[k] <= hist_reg[k-1];
                        end
                        hist_reg[0] <= range_cut;
                        sum_reg     <= sum_next;
                        num_reg     <= NUM_W'(sum_next) << rlfm_pkg::FRAC;
                        quo_reg     <= '0;
                        rem_reg     <= '0;
                        div_reg     <= fill;
                        cnt_reg     <= '0;
                        state_reg   <= L_DIV;
                    end
                end
                L_DIV:
                begin
                    rem_reg <= qbit ? FILL_W'(rem_shift - {1'b0, div_reg})
                                    : rem_shift[FILL_W-1:0];
                    num_reg <= num_reg << 1;
                    quo_reg <= {quo_reg[NUM_W-2:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NUM_W - 1))
                    begin
                        state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    px_reg    <= quo_reg[AVG_W-1:0] * cos_mag;
                    py_reg    <= quo_reg[AVG_W-1:0] * sin_mag;
                    state_reg <= L_RND;
                end
                L_RND:
                begin
                    x_reg     <= CRD_W'(x_round >> 15);
                    y_reg     <= sin_neg ? -y_mag : y_mag;
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
endmodule
`default_nettype wire

/* hw/rtl/rlfm_div.sv */
`default_nettype none
module rlfm_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [rlfm_pkg::DVD_W-1:0]      dividend,
    input  wire logic [rlfm_pkg::DVS_W-1:0]      divisor,
    output logic                                 done,
    output logic [rlfm_pkg::QUO_W-1:0]           quotient,
    output logic                                 overflow
);
    localparam int DVD_W  = rlfm_pkg::DVD_W;
    localparam int DVS_W  = rlfm_pkg::DVS_W;
    localparam int QUO_W  = rlfm_pkg::QUO_W;
    localparam int DCNT_W = rlfm_pkg::DCNT_W;

    logic               busy_reg;
    logic               done_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic [DVD_W-1:0]   num_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic               ovf_reg;

    logic [DVS_W:0]     rem_shift;
    logic               qbit;

    always_comb
    begin
        rem_shift = {rem_reg, num_reg[DVD_W-1]};
        qbit      = (rem_shift >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? DVS_W'(rem_shift - {1'b0, dvs_reg})
                                : rem_shift[DVS_W-1:0];
                num_reg <= num_reg << 1;
                // Quotient bits pushed past the top set the overflow flag, which the caller uses to saturate.
                quo_reg <= {quo_reg[QUO_W-2:0], qbit};
                ovf_reg <= ovf_reg | quo_reg[QUO_W-1];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign overflow = ovf_reg;
endmodule
`default_nettype wire

/* hw/rtl/rlfm_fit.sv */
`default_nettype none
module rlfm_fit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [rlfm_pkg::CRD_W-1:0]   x [rlfm_pkg::BEAMS],
    input  wire logic signed [rlfm_pkg::CRD_W-1:0]   y [rlfm_pkg::BEAMS],
    output logic                                     done,
    output rlfm_pkg::rlfm_fit_t                      fit
);
    localparam int BEAMS  = rlfm_pkg::BEAMS;
    localparam int CRD_W  = rlfm_pkg::CRD_W;
    localparam int ACC_W  = rlfm_pkg::ACC_W;
    localparam int QUO_W  = rlfm_pkg::QUO_W;
    localparam int DVD_W  = rlfm_pkg::DVD_W;
    localparam int DVS_W  = rlfm_pkg::DVS_W;
    localparam int MCNT_W = $clog2(2 * BEAMS);
    localparam int BI_W   = $clog2(BEAMS);
    localparam int QN_W   = ACC_W - 16;
    localparam int RCP_W  = 19;

    typedef enum logic [3:0] {
        F_IDLE, F_SUM, F_DEV, F_MAC, F_MEND, F_CHK, F_DIV1, F_PROD, F_B16, F_DIV2, F_BOUT
    } fit_state_t;

    fit_state_t               state_reg;
    logic signed [CRD_W-1:0]  sx_reg;
    logic signed [CRD_W-1:0]  sy_reg;
    logic signed [CRD_W-1:0]  dx_reg [BEAMS];
    logic signed [CRD_W-1:0]  dy_reg [BEAMS];
    logic [MCNT_W-1:0]        cnt_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic                     pv_reg;
    logic                     psel_reg;
    logic signed [ACC_W-1:0]  sxx_reg;
    logic signed [ACC_W-1:0]  sxy_reg;
    logic signed [CRD_W-1:0]  a_reg;
    logic signed [ACC_W-1:0]  p_reg;
    logic                     bneg_reg;
    logic [QN_W-1:0]          qn_reg;
    logic [2:0]               qrem_reg;
    logic [DVD_W-1:0]         dvd_reg;
    logic [DVS_W-1:0]         dvs_reg;
    logic                     dstart_reg;
    logic                     done_reg;
    rlfm_pkg::rlfm_fit_t      fit_reg;

    logic                     div_done;
    logic [QUO_W-1:0]         div_quo;
    logic                     div_ovf;
    logic signed [CRD_W-1:0]  sum_x;
    logic signed [CRD_W-1:0]  sum_y;
    logic [BI_W-1:0]          bi;
    logic signed [CRD_W-1:0]  op_b;
    logic [ACC_W-1:0]         sxy_mag;
    logic signed [ACC_W-1:0]  p_adj;
    logic signed [ACC_W-1:0]  t_val;
    logic signed [ACC_W-1:0]  sy_ext;
    logic signed [ACC_W-1:0]  b16_val;
    logic [ACC_W-1:0]         b16_mag;
    logic [RCP_W-1:0]         qv;
    logic [2*RCP_W-1:0]       qprod;
    logic [15:0]              qd;
    logic [RCP_W-1:0]         qsub;

    // Magnitude limited to 2^31 when negative and 2^31-1 when positive, sign applied.
    function automatic logic signed [CRD_W-1:0] sat_quo(
        input logic [QUO_W-1:0] q,
        input logic             ovf,
        input logic             neg
    );
        logic [QUO_W-1:0] lim;
        logic [QUO_W-1:0] qs;
        lim = neg ? QUO_W'(64'h8000_0000) : QUO_W'(64'h7fff_ffff);
        qs  = (ovf || q > lim) ? lim : q;
        return neg ? -$signed(qs[CRD_W-1:0]) : $signed(qs[CRD_W-1:0]);
    endfunction

    rlfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dstart_reg),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_quo),
        .overflow (div_ovf)
    );

    always_comb
    begin
        sum_x = '0;
        sum_y = '0;
        for (int i = 0; i < BEAMS; i++)
        begin
            sum_x = sum_x + x[i];
            sum_y = sum_y + y[i];
        end
        bi      = cnt_reg[MCNT_W-1:1];
        op_b    = cnt_reg[0] ? dy_reg[bi] : dx_reg[bi];
        sxy_mag = sxy_reg[ACC_W-1] ? ACC_W'(-sxy_reg) : ACC_W'(sxy_reg);
        // a * sum x in Q16 mm, truncated toward zero.
        p_adj   = p_reg[ACC_W-1] ? p_reg + $signed(ACC_W'((1 << rlfm_pkg::FRAC) - 1)) : p_reg;
        t_val   = p_adj >>> rlfm_pkg::FRAC;
        sy_ext  = $signed({{(ACC_W - CRD_W){sy_reg[CRD_W-1]}}, sy_reg}) <<< rlfm_pkg::BFRAC;
        b16_val = sy_ext - t_val;
        b16_mag = b16_val[ACC_W-1] ? ACC_W'(-b16_val) : ACC_W'(b16_val);
        // Long division by five, 16 bits per step; the partial remainder stays below five.
        qv      = {qrem_reg, qn_reg[QN_W-1:QN_W-16]};
        qprod   = qv * rlfm_pkg::RECIP_FIVE;
        qd      = 16'(qprod >> rlfm_pkg::RECIP_FIVE_SHIFT);
        qsub    = qv - RCP_W'(qd) * RCP_W'(5);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            dstart_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            dstart_reg <= 1'b0;
            if (pv_reg)
            begin
                if (psel_reg)
                begin
                    sxy_reg <= sxy_reg + prod_reg;
                end
                else
                begin
                    sxx_reg <= sxx_reg + prod_reg;
                end
            end
            unique case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= F_SUM;
                    end
                end
                F_SUM:
                begin
                    sx_reg    <= sum_x;
                    sy_reg    <= sum_y;
                    sxx_reg   <= '0;
                    sxy_reg   <= '0;
                    state_reg <= F_DEV;
                end
                F_DEV:
                begin
                    for (int i = 0; i < BEAMS; i++)
                    begin
                        dx_reg[i] <= (x[i] <<< 2) + x[i] - sx_reg;
                        dy_reg[i] <= (y[i] <<< 2) + y[i] - sy_reg;
                    end
                    cnt_reg   <= '0;
                    state_reg <= F_MAC;
                end
                F_MAC:
                begin
                    prod_reg <= dx_reg[bi] * op_b;
                    pv_reg   <= 1'b1;
                    psel_reg <= cnt_reg[0];
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == MCNT_W'(2 * BEAMS - 1))
                    begin
                        state_reg <= F_MEND;
                    end
                end
                F_MEND:
                begin
                    pv_reg    <= 1'b0;
                    state_reg <= F_CHK;
                end
                F_CHK:
                begin
                    if (sxx_reg == '0)
                    begin
                        fit_reg.slope      <= '0;
                        fit_reg.intercept  <= '0;
                        fit_reg.degenerate <= 1'b1;
                        done_reg           <= 1'b1;
                        state_reg          <= F_IDLE;
                    end
                    else
                    begin
                        dvd_reg    <= {sxy_mag, 16'h0000};
                        dvs_reg    <= DVS_W'(sxx_reg);
                        dstart_reg <= 1'b1;
                        state_reg  <= F_DIV1;
                    end
                end
                F_DIV1:
                begin
                    if (div_done)
                    begin
                        a_reg     <= sat_quo(div_quo, div_ovf, sxy_reg[ACC_W-1]);
                        state_reg <= F_PROD;
                    end
                end
                F_PROD:
                begin
                    p_reg     <= a_reg * sx_reg;
                    state_reg <= F_B16;
                end
                F_B16:
                begin
                    // Dropping the 16 fraction bits first leaves a division by five.
                    bneg_reg  <= b16_val[ACC_W-1];
                    qn_reg    <= b16_mag[ACC_W-1:16];
                    qrem_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= F_DIV2;
                end
                F_DIV2:
                begin
                    qn_reg   <= {qn_reg[QN_W-17:0], qd};
                    qrem_reg <= qsub[2:0];
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == MCNT_W'(QN_W / 16 - 1))
                    begin
                        state_reg <= F_BOUT;
                    end
                end
                F_BOUT:
                begin
                    fit_reg.slope      <= a_reg;
                    fit_reg.intercept  <= sat_quo(qn_reg[QUO_W-1:0], |qn_reg[QN_W-1:QUO_W],
                                                  bneg_reg);
                    fit_reg.degenerate <= 1'b0;
                    done_reg           <= 1'b1;
                    state_reg          <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign fit  = fit_reg;
endmodule
`default_nettype wire

/* hw/rtl/rlfm_median.sv */
`default_nettype none
module rlfm_median (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire rlfm_pkg::rlfm_fit_t    fit,
    output logic                        done,
    output rlfm_pkg::rlfm_result_t      result
);
    localparam int MD      = rlfm_pkg::MEDIAN_DEPTH;
    localparam int MFILL_W = rlfm_pkg::MFILL_W;
    localparam int MIDX_W  = rlfm_pkg::MIDX_W;
    localparam int CRD_W   = rlfm_pkg::CRD_W;

    typedef enum logic {M_IDLE, M_EVAL} med_state_t;

    med_state_t               state_reg;
    logic signed [CRD_W-1:0]  sw_reg [MD];
    logic signed [CRD_W-1:0]  iw_reg [MD];
    logic [MFILL_W-1:0]       mfill_reg;
    logic signed [CRD_W-1:0]  prev_reg;
    logic                     degen_reg;
    logic                     done_reg;
    rlfm_pkg::rlfm_result_t   res_reg;

    logic [MFILL_W-1:0]       rank [MD];
    logic [MFILL_W-1:0]       mid;
    logic signed [CRD_W-1:0]  ms;
    logic signed [CRD_W-1:0]  mb;
    logic                     flip;

    // Rank of each held slope in a stable ascending sort; ties keep age order.
    always_comb
    begin
        mid = mfill_reg >> 1;
        ms  = '0;
        mb  = '0;
        for (int i = 0; i < MD; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < MD; j++)
            begin
                if (MFILL_W'(j) < mfill_reg &&
                    (sw_reg[j] < sw_reg[i] || (sw_reg[j] == sw_reg[i] && j < i)))
                begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
        end
        for (int i = 0; i < MD; i++)
        begin
            if (MFILL_W'(i) < mfill_reg && rank[i] == mid)
            begin
                ms = sw_reg[i];
                mb = iw_reg[i];
            end
        end
        flip = !degen_reg && ((ms < 0 && prev_reg > 0) || (ms > 0 && prev_reg < 0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            mfill_reg <= '0;
            prev_reg  <= '0;
            done_reg  <= 1'b0;
            for (int k = 0; k < MD; k++)
            begin
                sw_reg[k] <= '0;
                iw_reg[k] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        degen_reg <= fit.degenerate;
                        if (!fit.degenerate)
                        begin
                            if (mfill_reg < MFILL_W'(MD))
                            begin
                                sw_reg[mfill_reg[MIDX_W-1:0]] <= fit.slope;
                                iw_reg[mfill_reg[MIDX_W-1:0]] <= fit.intercept;
                                mfill_reg <= mfill_reg + 1'b1;
                            end
                            else
                            begin
                                for (int k = 0; k < MD - 1; k++)
                                begin
                                    sw_reg[k] <= sw_reg[k+1];
                                    iw_reg[k] <= iw_reg[k+1];
                                end
                                sw_reg[MD-1] <= fit.slope;
                                iw_reg[MD-1] <= fit.intercept;
                            end
                        end
                        state_reg <= M_EVAL;
                    end
                end
                M_EVAL:
                begin
                    res_reg.slope      <= ms;
                    res_reg.intercept  <= mb;
                    res_reg.flip       <= flip;
                    res_reg.degenerate <= degen_reg;
                    if (!degen_reg)
                    begin
                        prev_reg <= ms;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    localparam int BEAMS         = rlfm_pkg::BEAMS;
    localparam int RANGE_IN_W    = rlfm_pkg::RANGE_IN_W;
    localparam int RANGE_BITS    = rlfm_pkg::RANGE_BITS;
    localparam int AVERAGE_DEPTH = rlfm_pkg::AVERAGE_DEPTH;
    localparam int MEDIAN_DEPTH  = rlfm_pkg::MEDIAN_DEPTH;
    localparam int CRD_W         = rlfm_pkg::CRD_W;
    localparam int FRAC          = rlfm_pkg::FRAC;
    localparam int BFRAC         = rlfm_pkg::BFRAC;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 300;

    typedef logic [RANGE_IN_W-1:0] scan_ranges_t [BEAMS];

    // Keeps its own copy of the filter state and predicts each scan's result.
    class line_fit_scoreboard;
        logic [RANGE_BITS-1:0]   history [BEAMS][AVERAGE_DEPTH];
        int unsigned             avg_fill;
        logic signed [CRD_W-1:0] slope_win [MEDIAN_DEPTH];
        logic signed [CRD_W-1:0] icpt_win [MEDIAN_DEPTH];
        int unsigned             fit_fill;
        logic signed [CRD_W-1:0] last_median;
        rlfm_pkg::rlfm_result_t  pending [$];
        int                      mismatches;

        function new();
            for (int c = 0; c < BEAMS; c++)
                for (int k = 0; k < AVERAGE_DEPTH; k++)
                    history[c][k] = '0;
            for (int k = 0; k < MEDIAN_DEPTH; k++)
            begin
                slope_win[k] = '0;
                icpt_win[k] = '0;
            end
            avg_fill = 0;
            fit_fill = 0;
            last_median = '0;
            mismatches = 0;
        endfunction

        function longint scale(longint unsigned avg, int unsigned mag, bit neg);
            longint r;
            r = longint'((avg * mag + 64'd16384) >> 15);
            return neg ? -r : r;
        endfunction

        function longint unsigned slope_div(longint unsigned n, longint unsigned d,
                                            longint unsigned lim);
            longint unsigned q, r;
            q = n / d;
            r = n % d;
            if (q > (lim >> 16))
                return lim;
            for (int k = 0; k < 16; k++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | 64'd1;
                end
            end
            return (q > lim) ? lim : q;
        endfunction

        function logic signed [CRD_W-1:0] clamp32(longint v);
            if (v > longint'(32'sh7fffffff))
                return 32'sh7fffffff;
            if (v < -longint'(64'h80000000))
                return 32'sh80000000;
            return v[CRD_W-1:0];
        endfunction

        // Stable sort by slope; returns the upper median entry.
        function void window_median(output logic signed [CRD_W-1:0] ms,
                                    output logic signed [CRD_W-1:0] mb);
            int unsigned order [MEDIAN_DEPTH];
            int j;
            if (fit_fill == 0)
            begin
                ms = '0;
                mb = '0;
                return;
            end
            for (int i = 0; i < fit_fill; i++)
            begin
                j = i;
                while (j > 0 && slope_win[order[j-1]] > slope_win[i])
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            ms = slope_win[order[fit_fill/2]];
            mb = icpt_win[order[fit_fill/2]];
        endfunction

        function void note_scan(scan_ranges_t r);
            longint x [BEAMS], y [BEAMS];
            longint sx, sy, sxx, sxy, dx, dy, a, hi, lo, t, b16;
            longint unsigned sum, avg, mag;
            logic signed [CRD_W-1:0] ms, mb, bi;
            rlfm_pkg::rlfm_result_t exp_res;
            bit degen, flip;
            sx = 0; sy = 0; sxx = 0; sxy = 0;
            flip = 0;
            if (avg_fill < AVERAGE_DEPTH)
                avg_fill++;
            for (int c = 0; c < BEAMS; c++)
            begin
                for (int k = AVERAGE_DEPTH - 1; k > 0; k--)
                    history[c][k] = history[c][k-1];
                history[c][0] = r[c][RANGE_BITS-1:0];
                sum = 0;
                for (int k = 0; k < avg_fill; k++)
                    sum += history[c][k];
                avg = (sum << FRAC) / avg_fill;
                x[c] = scale(avg, rlfm_pkg::COS_MAG[c], 1'b0);
                y[c] = scale(avg, rlfm_pkg::SIN_MAG[c], rlfm_pkg::SIN_NEG[c]);
                sx += x[c];
                sy += y[c];
            end
            for (int c = 0; c < BEAMS; c++)
            begin
                dx = 5 * x[c] - sx;
                dy = 5 * y[c] - sy;
                sxx += dx * dx;
                sxy += dx * dy;
            end
            degen = (sxx == 0);
            if (!degen)
            begin
                mag = (sxy < 0) ? longint'(-sxy) : longint'(sxy);
                if (sxy < 0)
                    a = -longint'(slope_div(mag, sxx, 64'h80000000));
                else
                    a = longint'(slope_div(mag, sxx, 64'h7fffffff));
                hi = sx / (longint'(1) << FRAC);
                lo = sx - hi * (longint'(1) << FRAC);
                t = a * hi + (a * lo) / (longint'(1) << FRAC);
                b16 = sy * (longint'(1) << BFRAC) - t;
                bi = clamp32(b16 / (5 * 65536));
                if (fit_fill < MEDIAN_DEPTH)
                begin
                    slope_win[fit_fill] = a[CRD_W-1:0];
                    icpt_win[fit_fill] = bi;
                    fit_fill++;
                end
                else
                begin
                    for (int k = 0; k + 1 < MEDIAN_DEPTH; k++)
                    begin
                        slope_win[k] = slope_win[k+1];
                        icpt_win[k] = icpt_win[k+1];
                    end
                    slope_win[MEDIAN_DEPTH-1] = a[CRD_W-1:0];
                    icpt_win[MEDIAN_DEPTH-1] = bi;
                end
            end
            window_median(ms, mb);
            if (!degen)
            begin
                flip = (ms < 0 && last_median > 0) || (ms > 0 && last_median < 0);
                last_median = ms;
            end
            exp_res.slope = ms;
            exp_res.intercept = mb;
            exp_res.flip = flip;
            exp_res.degenerate = degen;
            pending.push_back(exp_res);
        endfunction

        function void check_result(rlfm_pkg::rlfm_result_t got);
            rlfm_pkg::rlfm_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: slope %0d intercept %0d",
                             got.slope, got.intercept);
                return;
            end
            want = pending.pop_front();
            if (got.slope !== want.slope || got.intercept !== want.intercept ||
                got.flip !== want.flip || got.degenerate !== want.degenerate)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d %0d %0b %0b, actual %0d %0d %0b %0b",
                             want.slope, want.intercept, want.flip, want.degenerate,
                             got.slope, got.intercept, got.flip, got.degenerate);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    rlfm_scan_if scan ();
    rlfm_result_if result ();

    range_line_fit_median_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan.sink),
        .result (result.source)
    );

    line_fit_scoreboard fit_sb;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        fit_sb = new();
        send_idle_pct = 16;
        recv_idle_pct = 54;
        cycle_count = 0;
        rst_n = 1'b0;
        scan.valid = 1'b0;
        scan.range_beam0 = '0;
        scan.range_beam1 = '0;
        scan.range_beam2 = '0;
        scan.range_beam3 = '0;
        scan.range_beam4 = '0;
        result.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(negedge clk)
        if (rst_n)
            result.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        rlfm_pkg::rlfm_result_t got;
        if (rst_n && result.valid && result.ready)
        begin
            got.slope = result.median_slope;
            got.intercept = result.median_intercept;
            got.flip = result.slope_sign_flip;
            got.degenerate = result.degenerate_fit;
            fit_sb.check_result(got);
        end
    end

    // Drives one scan and waits for its transfer; valid is left high afterwards and drops only in idle gaps.
    task automatic send_scan(scan_ranges_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            scan.valid <= 1'b0;
        end
        @(negedge clk);
        scan.valid <= 1'b1;
        scan.range_beam0 <= r[0];
        scan.range_beam1 <= r[1];
        scan.range_beam2 <= r[2];
        scan.range_beam3 <= r[3];
        scan.range_beam4 <= r[4];
        do
            @(posedge clk);
        while (!scan.ready);
        fit_sb.note_scan(r);
    endtask

    task automatic send_all(logic [RANGE_IN_W-1:0] v);
        scan_ranges_t r;
        for (int c = 0; c < BEAMS; c++)
            r[c] = v;
        send_scan(r);
    endtask

    // Ranges that put all five points at nearly the same x.
    task automatic send_wall(int unsigned k);
        scan_ranges_t r;
        for (int c = 0; c < BEAMS; c++)
            r[c] = RANGE_IN_W'((k * 32768 + rlfm_pkg::COS_MAG[c] / 2) / rlfm_pkg::COS_MAG[c]);
        send_scan(r);
    endtask

    task automatic send_random;
        scan_ranges_t r;
        int mode, base, step, v;
        mode = $urandom_range(0, 9);
        if (mode <= 5)
        begin
            base = $urandom_range(100, 65000);
            step = int'($urandom_range(0, 8000)) - 4000;
            for (int c = 0; c < BEAMS; c++)
            begin
                v = base + step * (c - 2) + int'($urandom_range(0, 40)) - 20;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                r[c] = RANGE_IN_W'(v);
            end
            send_scan(r);
        end
        else if (mode == 6)
        begin
            for (int c = 0; c < BEAMS; c++)
                r[c] = RANGE_IN_W'($urandom_range(0, 65535));
            send_scan(r);
        end
        else if (mode == 7)
        begin
            for (int c = 0; c < BEAMS; c++)
                r[c] = RANGE_IN_W'($urandom_range(0, 3));
            send_scan(r);
        end
        else if (mode == 8)
        begin
            // One equal-range scan, or empty scans that flush the average and force a zero determinant.
            if ($urandom_range(0, 3) == 0)
                for (int k = 0; k < AVERAGE_DEPTH + 1; k++)
                    send_all('0);
            else
                send_all(RANGE_IN_W'($urandom_range(0, 65535)));
        end
        else
            send_wall($urandom_range(1, 60000));
    endtask

    initial
    begin
        scan_ranges_t r;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Degenerate with an empty window, then extremes and steep walls.
        send_all('0);
        send_all('0);
        send_all(16'hffff);
        send_all(16'hffff);
        r = '{16'd0, 16'd0, 16'd0, 16'd0, 16'hffff};
        send_scan(r);
        r = '{16'hffff, 16'd0, 16'd0, 16'd0, 16'd0};
        send_scan(r);
        r = '{16'hffff, 16'hffff, 16'd0, 16'd0, 16'd0};
        send_scan(r);
        r = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0};
        send_scan(r);
        r = '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555};
        send_scan(r);
        send_wall(1);
        send_wall(65000);
        send_wall(30000);
        r = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4};
        send_scan(r);
        r = '{16'd4, 16'd3, 16'd2, 16'd1, 16'd0};
        send_scan(r);
        for (int k = 0; k < AVERAGE_DEPTH + 1; k++)
            send_all('0);

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 16 : (p == 1) ? 54 : 0;
            recv_idle_pct = (p == 0) ? 54 : (p == 1) ? 16 : 0;
            for (int n = 0; n < 105; n++)
                send_random();
        end

        @(negedge clk);
        scan.valid <= 1'b0;
        while (fit_sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fit_sb.mismatches == 0 && fit_sb.pending.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
`default_nettype wire

/* range_line_fit_median_top.f */
+incdir+hw/rtl
hw/rtl/rlfm_pkg.sv
hw/rtl/rlfm_scan_if.sv
hw/rtl/rlfm_result_if.sv
hw/rtl/rlfm_lane.sv
hw/rtl/rlfm_div.sv
hw/rtl/rlfm_fit.sv
hw/rtl/rlfm_median.sv
hw/rtl/range_line_fit_median_top.sv
sim/testbench.sv
